FILE: design/cfl_tsmin_pkg.sv
`timescale 1ns / 1ps

package cfl_tsmin_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_USE_SOUND_SPEED  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_DIMS      = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DT_THRESHOLD = 2'd2;

	localparam logic       RST_USE_SOUND_SPEED  = 1'b1;
	localparam logic [1:0] RST_ACTIVE_DIMS      = 2'd3;
	localparam int         RST_MIN_DT_THRESHOLD = 7;

	localparam logic [1:0] DIR_X1 = 2'd0;
	localparam logic [1:0] DIR_X2 = 2'd1;
	localparam logic [1:0] DIR_X3 = 2'd2;

	localparam logic STATUS_DONE      = 1'b0;
	localparam logic STATUS_TOO_SMALL = 1'b1;

	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       check;
		logic       iter;
		logic       store;
		logic       eval;
		logic [1:0] dir;
	} cmd_t;

	typedef struct packed {
		logic discarding;
		logic out_free;
	} stat_t;

endpackage

FILE: design/cfl_tsmin_ctrl.sv
`timescale 1ns / 1ps

module cfl_tsmin_ctrl #(
	parameter int DATA_WIDTH = cfl_tsmin_pkg::DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cfl_tsmin_pkg::stat_t stat,
	output cfl_tsmin_pkg::cmd_t  cmd
);

	localparam int CNTW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DATA_WIDTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_ITER,
		S_STORE,
		S_EVAL
	} state_t;

	state_t          state_q;
	logic [1:0]      dir_q;
	logic [CNTW-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.dir     = dir_q;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.prep    = (state_q == S_PREP);
		cmd.check   = (state_q == S_CHECK);
		cmd.iter    = (state_q == S_ITER);
		cmd.store   = (state_q == S_STORE);
		cmd.eval    = (state_q == S_EVAL) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dir_q   <= cfl_tsmin_pkg::DIR_X1;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					dir_q <= cfl_tsmin_pkg::DIR_X1;
					if (in_valid && !stat.discarding) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_STORE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_STORE: begin
					if (dir_q == cfl_tsmin_pkg::DIR_X3) begin
						state_q <= S_EVAL;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_EVAL: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/cfl_tsmin_dp.sv
`timescale 1ns / 1ps

module cfl_tsmin_dp #(
	parameter int DATA_WIDTH = cfl_tsmin_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cfl_tsmin_pkg::FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  cfl_tsmin_pkg::cmd_t                        cmd,
	output cfl_tsmin_pkg::stat_t                       stat,
	input  logic                                       cfg_valid,
	input  logic [cfl_tsmin_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [DATA_WIDTH-1:0]                      cfg_data,
	input  logic [DATA_WIDTH-1:0]                      width_x1,
	input  logic [DATA_WIDTH-1:0]                      width_x2,
	input  logic [DATA_WIDTH-1:0]                      width_x3,
	input  logic signed [DATA_WIDTH-1:0]               vel_x1,
	input  logic signed [DATA_WIDTH-1:0]               vel_x2,
	input  logic signed [DATA_WIDTH-1:0]               vel_x3,
	input  logic [DATA_WIDTH-1:0]                      sound_speed,
	input  logic                                       last_in_sweep,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic                                       status,
	output logic [DATA_WIDTH-1:0]                      dt_value
);

	localparam int DW = DATA_WIDTH;
	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int CW = (FRAC_BITS > DATA_WIDTH + 1) ? FRAC_BITS : DATA_WIDTH + 1;
	localparam logic [DW-1:0] DMAX = '1;

	logic          use_ss_q;
	logic [1:0]    active_dims_q;
	logic [DW-1:0] threshold_q;

	logic [DW-1:0] w_q [3];
	logic [DW-1:0] v_q [3];
	logic [DW-1:0] cs_q;
	logic          last_q;

	logic [DW-1:0] num_q;
	logic [DW:0]   den_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] lo_q;
	logic [DW-1:0] quo_q;
	logic          sat_q;

	logic [DW-1:0] smallest_q;
	logic [DW-1:0] cand_q;
	logic [DW-1:0] running_min_q;
	logic          discarding_q;

	logic          out_valid_q;
	logic          status_q;
	logic [DW-1:0] dt_value_q;

	logic [DW-1:0]        v_sel;
	logic [DW-1:0]        v_mag;
	logic [NW-1:0]        num_ext;
	logic [FRAC_BITS-1:0] hi;
	logic [DW+1:0]        trial;
	logic                 ge;
	logic [DW-1:0]        dt_new;
	logic                 joins;
	logic                 too_small;
	logic [DW-1:0]        min_new;

	assign v_sel   = v_q[cmd.dir];
	assign v_mag   = v_sel[DW-1] ? (~v_sel + 1'b1) : v_sel;
	assign num_ext = {num_q, {FRAC_BITS{1'b0}}};
	assign hi      = num_ext[NW-1:DW];
	assign trial   = {rem_q, lo_q[DW-1]};
	assign ge      = (trial >= {1'b0, den_q});
	assign dt_new  = sat_q ? DMAX : quo_q;
	assign joins   = (cmd.dir == cfl_tsmin_pkg::DIR_X1)
		|| ((cmd.dir == cfl_tsmin_pkg::DIR_X2) && (active_dims_q >= 2'd2))
		|| ((cmd.dir == cfl_tsmin_pkg::DIR_X3) && (active_dims_q >= 2'd3));
	assign too_small = (smallest_q <= threshold_q);
	assign min_new   = (cand_q < running_min_q) ? cand_q : running_min_q;

	assign stat.discarding = discarding_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign dt_value  = dt_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_ss_q      <= cfl_tsmin_pkg::RST_USE_SOUND_SPEED;
			active_dims_q <= cfl_tsmin_pkg::RST_ACTIVE_DIMS;
			threshold_q   <= DW'(cfl_tsmin_pkg::RST_MIN_DT_THRESHOLD);
		end else if (cfg_valid) begin
			case (cfg_index)
				cfl_tsmin_pkg::CFG_USE_SOUND_SPEED:  use_ss_q      <= cfg_data[0];
				cfl_tsmin_pkg::CFG_ACTIVE_DIMS:      active_dims_q <= cfg_data[1:0];
				cfl_tsmin_pkg::CFG_MIN_DT_THRESHOLD: threshold_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// item capture, divider, per-cell minimum and result datapath
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q[0] <= width_x1;
			w_q[1] <= width_x2;
			w_q[2] <= width_x3;
			v_q[0] <= vel_x1;
			v_q[1] <= vel_x2;
			v_q[2] <= vel_x3;
			cs_q   <= sound_speed;
			last_q <= last_in_sweep;
		end
		if (cmd.prep) begin
			num_q <= w_q[cmd.dir];
			den_q <= {1'b0, v_mag} + {1'b0, (use_ss_q ? cs_q : {DW{1'b0}})};
		end
		if (cmd.check) begin
			sat_q <= (den_q == '0) || (CW'(hi) >= CW'(den_q));
			rem_q <= (DW+1)'(hi);
			lo_q  <= num_ext[DW-1:0];
		end
		if (cmd.iter) begin
			rem_q <= ge ? (DW+1)'(trial - {1'b0, den_q}) : trial[DW:0];
			quo_q <= {quo_q[DW-2:0], ge};
			lo_q  <= {lo_q[DW-2:0], 1'b0};
		end
		if (cmd.store) begin
			if (cmd.dir == cfl_tsmin_pkg::DIR_X1) begin
				smallest_q <= dt_new;
				cand_q     <= dt_new;
			end else begin
				if (dt_new < smallest_q) begin
					smallest_q <= dt_new;
				end
				if (joins && (dt_new < cand_q)) begin
					cand_q <= dt_new;
				end
			end
		end
		if (cmd.eval) begin
			status_q   <= too_small ? cfl_tsmin_pkg::STATUS_TOO_SMALL
			                        : cfl_tsmin_pkg::STATUS_DONE;
			dt_value_q <= too_small ? smallest_q : min_new;
		end
	end

	// sweep state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= DMAX;
			discarding_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.capture && discarding_q && last_in_sweep) begin
				discarding_q  <= 1'b0;
				running_min_q <= DMAX;
			end
			if (cmd.eval) begin
				if (too_small) begin
					running_min_q <= DMAX;
					discarding_q  <= !last_q;
				end else if (last_q) begin
					running_min_q <= DMAX;
				end else begin
					running_min_q <= min_new;
				end
			end
			if (cmd.eval && (too_small || last_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/cfl_timestep_min_reduction_core.sv
`timescale 1ns / 1ps

// cfl timestep minimum over a sweep of cells
// input channel in_valid / in_ready carries one cell per transaction; the
// last cell of a sweep has last_in_sweep set
// per cell three fixed point quotients width / (|v| + cs, or |v| with sound
// speed off) share one restoring divider in turn, one quotient bit per cycle
// a computed cell keeps in_ready low from acceptance until its result is
// evaluated, so a new cell waits until then; a cell that falls in a
// discarded part of a sweep is accepted without being computed
// a result transaction (status, dt_value) leaves on out_valid / out_ready
// when a sweep ends or a cell timestep is at or below the threshold;
// out_valid rises as the cell leaves its evaluation state
// the result sits in an output register; new cells are accepted while it
// waits, and the next computed cell holds in its evaluation step until taken
// configuration transactions on cfg_valid / cfg_ready are always taken;
// write them only while the block is idle
// reset clears the running minimum to all ones, ends any discard, drops
// out_valid and loads the register defaults

module cfl_timestep_min_reduction_core #(
	parameter int DATA_WIDTH = cfl_tsmin_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cfl_tsmin_pkg::FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [cfl_tsmin_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]                     cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [DATA_WIDTH-1:0]                     width_x1,
	input  logic [DATA_WIDTH-1:0]                     width_x2,
	input  logic [DATA_WIDTH-1:0]                     width_x3,
	input  logic signed [DATA_WIDTH-1:0]              vel_x1,
	input  logic signed [DATA_WIDTH-1:0]              vel_x2,
	input  logic signed [DATA_WIDTH-1:0]              vel_x3,
	input  logic [DATA_WIDTH-1:0]                     sound_speed,
	input  logic                                      last_in_sweep,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic                                      status,
	output logic [DATA_WIDTH-1:0]                     dt_value
);

	cfl_tsmin_pkg::cmd_t  cmd;
	cfl_tsmin_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	cfl_tsmin_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfl_tsmin_dp #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.width_x1      (width_x1),
		.width_x2      (width_x2),
		.width_x3      (width_x3),
		.vel_x1        (vel_x1),
		.vel_x2        (vel_x2),
		.vel_x3        (vel_x3),
		.sound_speed   (sound_speed),
		.last_in_sweep (last_in_sweep),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.dt_value      (dt_value)
	);

endmodule

FILE: tb/sv/cfl_timestep_min_reduction_checker.sv
`timescale 1ns / 1ps

module cfl_timestep_min_reduction_checker #(
	parameter int DATA_WIDTH = cfl_tsmin_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cfl_tsmin_pkg::FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	input  logic                                      cfg_ready,
	input  logic [cfl_tsmin_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]                     cfg_data,
	input  logic                                      in_valid,
	input  logic                                      in_ready,
	input  logic [DATA_WIDTH-1:0]                     width_x1,
	input  logic [DATA_WIDTH-1:0]                     width_x2,
	input  logic [DATA_WIDTH-1:0]                     width_x3,
	input  logic signed [DATA_WIDTH-1:0]              vel_x1,
	input  logic signed [DATA_WIDTH-1:0]              vel_x2,
	input  logic signed [DATA_WIDTH-1:0]              vel_x3,
	input  logic [DATA_WIDTH-1:0]                     sound_speed,
	input  logic                                      last_in_sweep,
	input  logic                                      out_valid,
	input  logic                                      out_ready,
	input  logic                                      status,
	input  logic [DATA_WIDTH-1:0]                     dt_value,
	output int                                        failures,
	output int                                        pending
);

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic  status;
		word_t dt_value;
	} sweep_result_t;

	sweep_result_t expected_results[$];

	logic  sound_on = cfl_tsmin_pkg::RST_USE_SOUND_SPEED;
	logic [1:0] dims = cfl_tsmin_pkg::RST_ACTIVE_DIMS;
	word_t threshold = word_t'(cfl_tsmin_pkg::RST_MIN_DT_THRESHOLD);
	word_t running_min = '1;
	logic  discarding = 1'b0;
	int    errors = 0;

	// width / den in fixed point, truncated, saturating at all ones
	function automatic word_t cell_dt(input word_t width, input word_t vel, input word_t cs);
		logic [DATA_WIDTH:0] den;
		logic [2*DATA_WIDTH+FRAC_BITS-1:0] quot;
		word_t mag;
		mag = vel[DATA_WIDTH-1] ? word_t'(~vel + 1'b1) : vel;
		den = {1'b0, mag} + {1'b0, cs};
		if (den == 0)
			return '1;
		quot = {{DATA_WIDTH{1'b0}}, width, {FRAC_BITS{1'b0}}} / den;
		if (quot[2*DATA_WIDTH+FRAC_BITS-1:DATA_WIDTH] != 0)
			return '1;
		return quot[DATA_WIDTH-1:0];
	endfunction

	task automatic predict_cell();
		word_t cs, dt1, dt2, dt3, least;
		cs = sound_on ? sound_speed : '0;
		if (discarding) begin
			if (last_in_sweep) begin
				discarding = 1'b0;
				running_min = '1;
			end
		end else begin
			dt1 = cell_dt(width_x1, vel_x1, cs);
			dt2 = cell_dt(width_x2, vel_x2, cs);
			dt3 = cell_dt(width_x3, vel_x3, cs);
			least = dt1;
			if (dt2 < least) least = dt2;
			if (dt3 < least) least = dt3;
			if (least <= threshold) begin
				expected_results.push_back({cfl_tsmin_pkg::STATUS_TOO_SMALL, least});
				running_min = '1;
				discarding = !last_in_sweep;
			end else begin
				if (dt1 < running_min) running_min = dt1;
				if (dims >= 2 && dt2 < running_min) running_min = dt2;
				if (dims >= 3 && dt3 < running_min) running_min = dt3;
				if (last_in_sweep) begin
					expected_results.push_back({cfl_tsmin_pkg::STATUS_DONE, running_min});
					running_min = '1;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sweep_result_t want;
		if (!arst_n) begin
			sound_on = cfl_tsmin_pkg::RST_USE_SOUND_SPEED;
			dims = cfl_tsmin_pkg::RST_ACTIVE_DIMS;
			threshold = word_t'(cfl_tsmin_pkg::RST_MIN_DT_THRESHOLD);
			running_min = '1;
			discarding = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: status %0d dt_value %h",
						status, dt_value);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						errors++;
					end
					if (dt_value !== want.dt_value) begin
						$error("dt_value mismatch: expected %h, actual %h",
							want.dt_value, dt_value);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfl_tsmin_pkg::CFG_USE_SOUND_SPEED:  sound_on = cfg_data[0];
					cfl_tsmin_pkg::CFG_ACTIVE_DIMS:      dims = cfg_data[1:0];
					cfl_tsmin_pkg::CFG_MIN_DT_THRESHOLD: threshold = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_cell();
			pending <= expected_results.size();
		end
		failures <= errors;
	end

endmodule

FILE: tb/sv/cfl_timestep_min_reduction_core_tb.sv
`timescale 1ns / 1ps

module cfl_timestep_min_reduction_core_tb;

	localparam int DATA_WIDTH    = cfl_tsmin_pkg::DATA_WIDTH_DEF;
	localparam int FRAC_BITS     = cfl_tsmin_pkg::FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = 3 * (DATA_WIDTH + 3) + 2 + 20;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef logic [DATA_WIDTH-1:0] word_t;

	localparam word_t ONE = word_t'(1) << FRAC_BITS;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [cfl_tsmin_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	word_t                      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	word_t                      width_x1, width_x2, width_x3;
	logic signed [DATA_WIDTH-1:0] vel_x1, vel_x2, vel_x3;
	word_t                      sound_speed;
	logic                       last_in_sweep;
	logic                       out_valid;
	logic                       out_ready;
	logic                       status;
	word_t                      dt_value;

	int failures;
	int pending;
	int sent;
	int cycles;
	int hold;
	bit calm;

	cfl_timestep_min_reduction_core #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.width_x1     (width_x1),
		.width_x2     (width_x2),
		.width_x3     (width_x3),
		.vel_x1       (vel_x1),
		.vel_x2       (vel_x2),
		.vel_x3       (vel_x3),
		.sound_speed  (sound_speed),
		.last_in_sweep(last_in_sweep),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.dt_value     (dt_value)
	);

	cfl_timestep_min_reduction_checker #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dt_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.width_x1     (width_x1),
		.width_x2     (width_x2),
		.width_x3     (width_x3),
		.vel_x1       (vel_x1),
		.vel_x2       (vel_x2),
		.vel_x3       (vel_x3),
		.sound_speed  (sound_speed),
		.last_in_sweep(last_in_sweep),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.dt_value     (dt_value),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				hold = calm ? 0 : $urandom_range(0, 19);
				out_ready <= (hold == 0);
			end else if (hold > 0) begin
				hold--;
				out_ready <= (hold == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return word_t'($urandom_range(0, 255));
			3: return word_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
			4: return word_t'($urandom_range(0, 32'h0003_ffff));
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic word_t pick_vel();
		word_t v;
		v = pick_word();
		if ($urandom_range(0, 1))
			v = ~v + 1'b1;
		return v;
	endfunction

	task automatic send_cell(input word_t w1, input word_t w2, input word_t w3,
		input word_t v1, input word_t v2, input word_t v3, input word_t cs,
		input logic last);
		int gap;
		in_valid      <= 1'b1;
		width_x1      <= w1;
		width_x2      <= w2;
		width_x3      <= w3;
		vel_x1        <= v1;
		vel_x2        <= v2;
		vel_x3        <= v3;
		sound_speed   <= cs;
		last_in_sweep <= last;
		@(posedge clk);
		while (!(in_valid && in_ready)) @(posedge clk);
		sent++;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input logic last);
		send_cell(pick_word(), pick_word(), pick_word(),
			pick_vel(), pick_vel(), pick_vel(), pick_word(), last);
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic quiesce();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cfl_tsmin_pkg::CFG_INDEX_WIDTH-1:0] idx,
		input word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic sound, input logic [1:0] dims, input word_t thr);
		write_reg(cfl_tsmin_pkg::CFG_USE_SOUND_SPEED, word_t'(sound));
		write_reg(cfl_tsmin_pkg::CFG_ACTIVE_DIMS, word_t'(dims));
		write_reg(cfl_tsmin_pkg::CFG_MIN_DT_THRESHOLD, thr);
	endtask

	// mostly well-formed sweeps, some loose cells with a random last flag
	task automatic random_sweeps(input int target);
		int start;
		int len;
		start = sent;
		while (sent - start < target) begin
			if ($urandom_range(0, 9) == 0) begin
				send_random($urandom_range(0, 1));
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_random(i == len - 1);
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	task automatic run_phase(input logic sound, input logic [1:0] dims, input word_t thr,
		input int target, input bit quiet);
		quiesce();
		configure(sound, dims, thr);
		calm = quiet;
		random_sweeps(target);
	endtask

	initial begin
		arst_n        = 1'b0;
		calm          = 1'b0;
		sent          = 0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		width_x1      = '0;
		width_x2      = '0;
		width_x3      = '0;
		vel_x1        = '0;
		vel_x2        = '0;
		vel_x3        = '0;
		sound_speed   = '0;
		last_in_sweep = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: sound speed on, three dims, threshold 7
		send_cell(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1);
		send_cell('0, '0, '0, '0, '0, '0, '0, 1'b1);
		send_cell('1, '1, '1, word_t'(1), word_t'(1), word_t'(1), '0, 1'b0);
		send_cell(2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE, ONE, 1'b1);
		send_cell('1, '1, '1, word_t'(1) << (DATA_WIDTH - 1), word_t'(1) << (DATA_WIDTH - 1),
			word_t'(1) << (DATA_WIDTH - 1), '1, 1'b1);
		send_cell(3 * ONE, 5 * ONE, '1, ONE, -2 * ONE, {1'b0, {(DATA_WIDTH-1){1'b1}}},
			ONE / 2, 1'b1);
		send_cell(word_t'(7), ONE, ONE, ONE, ONE, ONE, '0, 1'b0);
		send_cell('0, '0, '0, ONE, ONE, ONE, '0, 1'b0);
		send_cell(ONE, ONE, ONE, ONE, ONE, ONE, '0, 1'b0);
		send_cell(ONE, ONE, ONE, ONE, ONE, ONE, '0, 1'b1);
		send_cell(ONE, word_t'(8), ONE, ONE, ONE, ONE, '0, 1'b1);
		send_cell(ONE, ONE, '0, ONE, ONE, ONE, '0, 1'b1);
		send_cell(ONE, ONE, ONE, ONE, ONE, ONE, '0, 1'b1);
		send_cell(4 * ONE, 4 * ONE, 4 * ONE, ONE, ONE, ONE, '0, 1'b0);
		send_cell(ONE, word_t'(3), ONE, ONE, ONE, ONE, '0, 1'b0);
		send_cell('0, '0, '0, '0, '0, '0, '0, 1'b1);
		send_cell(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1);

		// pure advection, only direction 1 in the running minimum
		quiesce();
		configure(1'b0, 2'd1, word_t'(7));
		send_cell(3 * ONE, ONE, 9 * ONE, ONE, 2 * ONE, ONE, '1, 1'b1);
		send_cell(ONE, ONE, '0, ONE, ONE, word_t'(1), '1, 1'b1);
		send_cell(ONE, ONE, ONE, '0, '0, '0, ONE, 1'b1);
		send_cell(word_t'(1), '1, '1, '1, '1, '1, '0, 1'b1);

		run_phase(1'b1, 2'd3, word_t'(7), 130, 1'b0);
		run_phase(1'b0, 2'd1, '0, 130, 1'b0);
		run_phase(1'b1, 2'd2, word_t'($urandom_range(0, 65535)), 130, 1'b1);
		run_phase(1'b1, 2'd3, '1, 40, 1'b0);
		run_phase(1'b0, 2'd3, word_t'($urandom_range(0, 32'h000f_ffff)), 130, 1'b0);
		run_phase(1'b1, 2'd0, word_t'(100), 130, 1'b0);
		run_phase(1'b0, 2'd2, '0, 130, 1'b0);
		run_phase(1'b1, 2'd3, word_t'($urandom), 40, 1'b0);
		run_phase(1'b1, 2'd1, word_t'($urandom_range(0, 4096)), 130, 1'b1);
		run_phase(cfl_tsmin_pkg::RST_USE_SOUND_SPEED, cfl_tsmin_pkg::RST_ACTIVE_DIMS,
			word_t'(cfl_tsmin_pkg::RST_MIN_DT_THRESHOLD), 40, 1'b0);

		quiesce();
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
design/cfl_tsmin_pkg.sv
design/cfl_tsmin_ctrl.sv
design/cfl_tsmin_dp.sv
design/cfl_timestep_min_reduction_core.sv
tb/sv/cfl_timestep_min_reduction_checker.sv
tb/sv/cfl_timestep_min_reduction_core_tb.sv
